// File: rtl/core/tgrb_pkg.sv
// Shared types, codes and defaults for the text glyph row blitter.
package tgrb_pkg;

   localparam int GLYPH_COUNT_DEF   = 96;
   localparam int MAX_GLYPH_DIM_DEF = 32;
   localparam int FIRST_CODE        = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 64;
   localparam int USER_W      = 2;
   localparam int OFFSET_W    = 20;
   localparam int DIM_W       = 6;

   // command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_DRAW  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_SPACING  = 3'd4;

   localparam logic [10:0] CANVAS_WIDTH_RST  = 11'd128;
   localparam logic [10:0] CANVAS_HEIGHT_RST = 11'd64;
   localparam logic [5:0]  GLYPH_WIDTH_RST   = 6'd8;
   localparam logic [5:0]  GLYPH_HEIGHT_RST  = 6'd8;
   localparam logic [4:0]  CHAR_SPACING_RST  = 5'd1;

   typedef struct packed {
      logic [10:0] canvas_width;
      logic [10:0] canvas_height;
      logic [5:0]  glyph_width;
      logic [5:0]  glyph_height;
      logic [4:0]  char_spacing;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_CHECK,
      ST_ROWS,
      ST_ERR
   } seq_state_type;

endpackage

// File: rtl/core/text_glyph_row_blitter.sv
// Top level of the text glyph row blitter: register file, sequencer, glyph RAM.
//
// The req_ channel carries commands: load a glyph row into the store, start a
// string at a canvas position, or draw one character at the text cursor. The
// rsp_ channel returns canvas spans (offset, length, foreground mask), gap
// spans and error items; tlast marks the final item caused by one command.
// Registers are written through csr_we/csr_index/csr_wdata; the user must do
// so only while idle, since the block itself does not enforce it.
// A load or a start is taken in the idle state; a failed start then emits its
// error item. A draw checks the code and the spacing at accept, emits H gap
// spans when spacing applies (H being the clamped glyph height), checks the
// glyph bound, then emits H rows from the single read port of the glyph RAM,
// which runs one row ahead and yields one span per cycle unless rsp_ stalls.
// Results pass through an output register, so a new command is taken while
// the final item of the previous one still waits.
// A stall on rsp_ holds the output register and the RAM read ahead; no item is
// dropped. Reset clears the cursor and marks the string aborted; the glyph
// store is not cleared, so rows must be loaded before they are drawn.
module text_glyph_row_blitter #(
   parameter int GLYPH_COUNT   = tgrb_pkg::GLYPH_COUNT_DEF,
   parameter int MAX_GLYPH_DIM = tgrb_pkg::MAX_GLYPH_DIM_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tgrb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgrb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // char_code[7:0], row_index[12:8], row_bits[44:13], start_x[54:45],
   // start_y[64:55], zero[71:65]
   input  logic [tgrb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[1:0]
   input  logic [tgrb_pkg::USER_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // row_offset[19:0], span_length[25:20], fore_mask[57:26], zero[63:58]
   output logic [tgrb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // is_gap[0], error[1]
   output logic [tgrb_pkg::USER_W-1:0]      rsp_tuser,
   output logic                             rsp_tlast
);
   import tgrb_pkg::*;

   localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width  <= CANVAS_WIDTH_RST;
         cfg_ff.canvas_height <= CANVAS_HEIGHT_RST;
         cfg_ff.glyph_width   <= GLYPH_WIDTH_RST;
         cfg_ff.glyph_height  <= GLYPH_HEIGHT_RST;
         cfg_ff.char_spacing  <= CHAR_SPACING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  cfg_ff.canvas_width  <= csr_wdata;
            CSR_CANVAS_HEIGHT: cfg_ff.canvas_height <= csr_wdata;
            CSR_GLYPH_WIDTH:   cfg_ff.glyph_width   <= csr_wdata[5:0];
            CSR_GLYPH_HEIGHT:  cfg_ff.glyph_height  <= csr_wdata[5:0];
            CSR_CHAR_SPACING:  cfg_ff.char_spacing  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [31:0]         ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [31:0]         ram_rdata;
   logic [OFFSET_W-1:0] rsp_row_offset;
   logic [DIM_W-1:0]    rsp_span_length;
   logic [31:0]         rsp_fore_mask;
   logic                rsp_is_gap;
   logic                rsp_error;

   tgrb_sequencer #(
      .GLYPH_COUNT   (GLYPH_COUNT),
      .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_cmd         (req_tuser[1:0]),
      .req_char_code   (req_tdata[7:0]),
      .req_row_index   (req_tdata[12:8]),
      .req_row_bits    (req_tdata[44:13]),
      .req_start_x     (req_tdata[54:45]),
      .req_start_y     (req_tdata[64:55]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_row_offset  (rsp_row_offset),
      .rsp_span_length (rsp_span_length),
      .rsp_fore_mask   (rsp_fore_mask),
      .rsp_is_gap      (rsp_is_gap),
      .rsp_error       (rsp_error),
      .rsp_last        (rsp_tlast),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata)
   );

   tgrb_glyph_ram #(
      .DEPTH (DEPTH)
   ) u_glyph_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tdata = {6'd0, rsp_fore_mask, rsp_span_length, rsp_row_offset};
   assign rsp_tuser = {rsp_error, rsp_is_gap};

endmodule

// File: rtl/core/tgrb_glyph_ram.sv
// Glyph row store: one write port, one registered read port.
module tgrb_glyph_ram #(
   parameter  int DEPTH  = tgrb_pkg::GLYPH_COUNT_DEF * tgrb_pkg::MAX_GLYPH_DIM_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [31:0]       wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [31:0]       rdata
);
   logic [31:0] glyph_mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         glyph_mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= glyph_mem[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: rtl/core/tgrb_sequencer.sv
// Command sequencer: cursor state, bounds checks and span generation.
module tgrb_sequencer #(
   parameter  int GLYPH_COUNT   = tgrb_pkg::GLYPH_COUNT_DEF,
   parameter  int MAX_GLYPH_DIM = tgrb_pkg::MAX_GLYPH_DIM_DEF,
   localparam int ADDR_W        = $clog2(GLYPH_COUNT * MAX_GLYPH_DIM)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tgrb_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [7:0]                    req_char_code,
   input  logic [4:0]                    req_row_index,
   input  logic [31:0]                   req_row_bits,
   input  logic [9:0]                    req_start_x,
   input  logic [9:0]                    req_start_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tgrb_pkg::OFFSET_W-1:0] rsp_row_offset,
   output logic [tgrb_pkg::DIM_W-1:0]    rsp_span_length,
   output logic [31:0]                   rsp_fore_mask,
   output logic                          rsp_is_gap,
   output logic                          rsp_error,
   output logic                          rsp_last,
   output logic                          ram_we,
   output logic [ADDR_W-1:0]             ram_waddr,
   output logic [31:0]                   ram_wdata,
   output logic                          ram_re,
   output logic [ADDR_W-1:0]             ram_raddr,
   input  logic [31:0]                   ram_rdata
);
   import tgrb_pkg::*;

   localparam int ROW_W = $clog2(MAX_GLYPH_DIM);

   function automatic logic code_ok(input logic [7:0] code);
      return ({1'b0, code} >= 9'(FIRST_CODE)) &&
             ({1'b0, code} < 9'(FIRST_CODE + GLYPH_COUNT));
   endfunction

   function automatic logic [ADDR_W-1:0] glyph_addr(input logic [7:0] idx,
                                                    input logic [4:0] row);
      return ADDR_W'(ADDR_W'(idx) * ADDR_W'(MAX_GLYPH_DIM)) + ADDR_W'(row);
   endfunction

   // pixel k of the row is bit width-1-k: reverse, then drop the unused top
   function automatic logic [31:0] row_mask(input logic [31:0] bits,
                                            input logic [5:0]  width);
      logic [31:0] rev;
      for (int i = 0; i < 32; i++) begin
         rev[i] = bits[31-i];
      end
      return rev >> (6'd32 - width);
   endfunction

   seq_state_type state_ff, state_in;
   logic [10:0]   cursor_x_ff, cursor_x_in;
   logic [9:0]    cursor_y_ff, cursor_y_in;
   logic          first_ff, first_in;
   logic          aborted_ff, aborted_in;
   logic [7:0]    code_idx_ff, code_idx_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [DIM_W-1:0]    count_ff, count_in;
   logic [DIM_W-1:0]    issue_ff, issue_in;
   logic          rd_valid_ff, rd_valid_in;

   logic                rsp_valid_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [DIM_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [31:0]         rsp_mask_ff, rsp_mask_in;
   logic                rsp_gap_ff, rsp_gap_in;
   logic                rsp_err_ff, rsp_err_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                emit;
   logic                can_load;
   logic                issue;
   logic [DIM_W-1:0]    gw;
   logic [DIM_W-1:0]    gh;
   logic [OFFSET_W-1:0] base_off;

   assign gw = (cfg.glyph_width > DIM_W'(MAX_GLYPH_DIM)) ?
               DIM_W'(MAX_GLYPH_DIM) : cfg.glyph_width;
   assign gh = (cfg.glyph_height > DIM_W'(MAX_GLYPH_DIM)) ?
               DIM_W'(MAX_GLYPH_DIM) : cfg.glyph_height;

   // span start of the cursor's top row, wrapped to the offset width
   assign base_off = OFFSET_W'(21'(cursor_y_ff) * 21'(cfg.canvas_width) +
                               21'(cursor_x_ff));

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign ram_waddr = glyph_addr(req_char_code - 8'(FIRST_CODE), req_row_index);
   assign ram_wdata = req_row_bits;
   assign ram_raddr = glyph_addr(code_idx_ff, 5'(issue_ff[ROW_W-1:0]));

   always_comb begin
      state_in      = state_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      first_in      = first_ff;
      aborted_in    = aborted_ff;
      code_idx_in   = code_idx_ff;
      off_in        = off_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_valid_in   = rd_valid_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      issue         = 1'b0;
      emit          = 1'b0;
      rsp_offset_in = '0;
      rsp_len_in    = '0;
      rsp_mask_in   = '0;
      rsp_gap_in    = 1'b0;
      rsp_err_in    = 1'b0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD: begin
                     if (code_ok(req_char_code) &&
                         ({1'b0, req_row_index} < 6'(MAX_GLYPH_DIM))) begin
                        ram_we = 1'b1;
                     end
                  end
                  CMD_START: begin
                     cursor_x_in = 11'(req_start_x);
                     cursor_y_in = req_start_y;
                     first_in    = 1'b1;
                     if (12'(req_start_y) + 12'(gh) > 12'(cfg.canvas_height)) begin
                        aborted_in = 1'b1;
                        state_in   = ST_ERR;
                     end else begin
                        aborted_in = 1'b0;
                     end
                  end
                  CMD_DRAW: begin
                     if (!aborted_ff) begin
                        code_idx_in = req_char_code - 8'(FIRST_CODE);
                        count_in    = '0;
                        off_in      = base_off;
                        if (!code_ok(req_char_code)) begin
                           aborted_in = 1'b1;
                           state_in   = ST_ERR;
                        end else if (!first_ff) begin
                           if (12'(cursor_x_ff) + 12'(cfg.char_spacing) >=
                               12'(cfg.canvas_width)) begin
                              aborted_in = 1'b1;
                              state_in   = ST_ERR;
                           end else begin
                              cursor_x_in = cursor_x_ff + 11'(cfg.char_spacing);
                              if (cfg.char_spacing != '0 && gh != '0) begin
                                 state_in = ST_GAP;
                              end else begin
                                 state_in = ST_CHECK;
                              end
                           end
                        end else begin
                           state_in = ST_CHECK;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_GAP: begin
            if (can_load) begin
               emit          = 1'b1;
               rsp_gap_in    = 1'b1;
               rsp_offset_in = off_ff;
               rsp_len_in    = DIM_W'(cfg.char_spacing);
               off_in        = off_ff + OFFSET_W'(cfg.canvas_width);
               count_in      = count_ff + 1'b1;
               if (count_ff + 1'b1 == gh) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            count_in    = '0;
            issue_in    = '0;
            rd_valid_in = 1'b0;
            off_in      = base_off;
            if (12'(cursor_x_ff) + 12'(gw) > 12'(cfg.canvas_width)) begin
               aborted_in = 1'b1;
               state_in   = ST_ERR;
            end else if (gh == '0) begin
               cursor_x_in = cursor_x_ff + 11'(gw);
               first_in    = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            emit   = rd_valid_ff && can_load;
            // keep one row read ahead; the RAM output holds while stalled
            issue  = (issue_ff < gh) && (!rd_valid_ff || emit);
            ram_re = issue;
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            rd_valid_in = issue || (rd_valid_ff && !emit);
            if (emit) begin
               rsp_offset_in = off_ff;
               rsp_len_in    = gw;
               rsp_mask_in   = row_mask(ram_rdata, gw);
               off_in        = off_ff + OFFSET_W'(cfg.canvas_width);
               count_in      = count_ff + 1'b1;
               if (count_ff + 1'b1 == gh) begin
                  rsp_last_in = 1'b1;
                  cursor_x_in = cursor_x_ff + 11'(gw);
                  first_in    = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (can_load) begin
               emit        = 1'b1;
               rsp_err_in  = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         first_ff    <= 1'b1;
         aborted_ff  <= 1'b1;
         count_ff    <= '0;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         first_ff    <= first_in;
         aborted_ff  <= aborted_in;
         count_ff    <= count_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_idx_ff <= code_idx_in;
      off_ff      <= off_in;
   end

   // output register: take a new item whenever the slot is free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_offset_ff <= rsp_offset_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_mask_ff   <= rsp_mask_in;
         rsp_gap_ff    <= rsp_gap_in;
         rsp_err_ff    <= rsp_err_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_offset  = rsp_offset_ff;
   assign rsp_span_length = rsp_len_ff;
   assign rsp_fore_mask   = rsp_mask_ff;
   assign rsp_is_gap      = rsp_gap_ff;
   assign rsp_error       = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: rtl/core/tgrb_checker.sv
// Port-level checks for the text glyph row blitter, bound to the top level.
module tgrb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // an error item ends its command and carries no span
   a_error_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0] && rsp_tdata == 64'd0)
      else $error("error item with span data or without tlast");

   // a gap is always followed by glyph rows or an error
   a_gap_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tlast)
      else $error("gap span marked last");

   a_span_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:20] <= 6'd32 && rsp_tdata[63:58] == 6'd0)
      else $error("span length beyond glyph limit or padding set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled item changed");

endmodule

bind text_glyph_row_blitter tgrb_checker u_tgrb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
